// ----- rtl/ptbrf_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the packed two-bit range filter count core.
package ptbrf_pkg;

  localparam int FIELDS_PER_WORD  = 16;
  localparam int DEF_MAX_FIELDS   = 1024;
  localparam int DEF_COUNT_BITS   = 16;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_FIELDS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH = 2'd2;

  localparam logic [10:0] NUM_FIELDS_RST = 11'd1024;
  localparam logic [2:0]  RANGE_LOW_RST  = 3'd0;
  localparam logic [2:0]  RANGE_HIGH_RST = 3'd4;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_ACCUM = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [5:0]  group_index;
    logic [31:0] packed_word;
  } in_word_t;

  typedef struct packed {
    logic [9:0]  field_number;
    logic        all_in_range;
    logic [15:0] match_count;
    logic        last;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic capture;
    logic row_wr;
    logic emit_start;
    logic emit_step;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       grp_ok;
    logic       in_use;
    logic       is_last;
    logic       out_free;
  } dp_sts_t;

endpackage

// ----- rtl/ptbrf_dp.sv -----
`timescale 1ns / 1ps
// Datapath: config registers, group row stores, field update logic and result register.
module ptbrf_dp import ptbrf_pkg::*; #(
  parameter int MAX_FIELDS = DEF_MAX_FIELDS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  in_word_t              in_word,
  input  logic                  out_stall,
  output logic                  out_valid,
  output out_word_t             out_word,
  input  ctrl_cmd_t             cmd,
  output dp_sts_t               sts
);

  localparam int NUM_GROUPS = MAX_FIELDS / FIELDS_PER_WORD;
  localparam int AW         = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;
  localparam int ROW_W      = FIELDS_PER_WORD * COUNT_BITS;
  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  logic [10:0] num_fields_r;
  logic [2:0]  range_low_r;
  logic [2:0]  range_high_r;

  logic [1:0]  cmd_r;
  logic [5:0]  grp_r;
  logic [31:0] word_r;
  logic [3:0]  j_r;

  logic [FIELDS_PER_WORD-1:0] mask_mem [NUM_GROUPS];
  logic [ROW_W-1:0]           cnt_mem  [NUM_GROUPS];
  logic [FIELDS_PER_WORD-1:0] mask_q;
  logic [ROW_W-1:0]           cnt_q;

  logic [FIELDS_PER_WORD-1:0] mask_wr;
  logic [ROW_W-1:0]           cnt_wr;
  logic [AW-1:0]              rd_addr;
  logic [AW-1:0]              wr_addr;

  logic                       out_valid_r;
  out_word_t                  out_word_r;

  logic [10:0]                emit_f;
  logic [10:0]                emit_f_next;
  logic [COUNT_BITS-1:0]      emit_cnt;
  logic [31:0]                emit_cnt32;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_fields_r <= NUM_FIELDS_RST;
      range_low_r  <= RANGE_LOW_RST;
      range_high_r <= RANGE_HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NUM_FIELDS: num_fields_r <= cfg_wdata;
        CFG_RANGE_LOW:  range_low_r  <= cfg_wdata[2:0];
        CFG_RANGE_HIGH: range_high_r <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r  <= in_word.command;
      grp_r  <= in_word.group_index;
      word_r <= in_word.packed_word;
    end
  end

  assign rd_addr = AW'(in_word.group_index);
  assign wr_addr = AW'(grp_r);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mask_q <= mask_mem[rd_addr];
      cnt_q  <= cnt_mem[rd_addr];
    end
    if (cmd.row_wr) begin
      mask_mem[wr_addr] <= mask_wr;
      cnt_mem[wr_addr]  <= cnt_wr;
    end
  end

  always_comb begin
    logic [1:0]            code;
    logic [2:0]            code3;
    logic [10:0]           f;
    logic                  used;
    logic                  in_mask;
    logic                  in_cnt;
    logic [COUNT_BITS-1:0] c;
    mask_wr = mask_q;
    cnt_wr  = cnt_q;
    for (int j = 0; j < FIELDS_PER_WORD; j++) begin
      code    = word_r[2*(FIELDS_PER_WORD-1-j) +: 2];
      code3   = {1'b0, code};
      f       = {1'b0, grp_r, 4'(j)};
      used    = f < num_fields_r;
      in_mask = (code3 >= range_low_r) && (code3 < range_high_r);
      in_cnt  = (code3 > range_low_r) && (code3 < range_high_r);
      c       = cnt_q[j*COUNT_BITS +: COUNT_BITS];
      if (cmd_r == CMD_CLEAR) begin
        mask_wr[j] = 1'b1;
        cnt_wr[j*COUNT_BITS +: COUNT_BITS] = '0;
      end else begin
        mask_wr[j] = mask_q[j] & (~used | in_mask);
        if (used && in_cnt && (c != CNT_MAX)) begin
          cnt_wr[j*COUNT_BITS +: COUNT_BITS] = c + COUNT_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      j_r <= '0;
    end else if (cmd.emit_start) begin
      j_r <= '0;
    end else if (cmd.emit_step) begin
      j_r <= j_r + 4'd1;
    end
  end

  assign emit_f      = {1'b0, grp_r, j_r};
  assign emit_f_next = emit_f + 11'd1;
  assign emit_cnt    = cnt_q[j_r*COUNT_BITS +: COUNT_BITS];
  assign emit_cnt32  = 32'(emit_cnt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_step) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_step) begin
      out_word_r.field_number <= emit_f[9:0];
      out_word_r.all_in_range <= mask_q[j_r];
      out_word_r.match_count  <= (emit_cnt32 > 32'hFFFF) ? 16'hFFFF : emit_cnt32[15:0];
      out_word_r.last         <= sts.is_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign sts.cmd      = cmd_r;
  assign sts.grp_ok   = 32'(grp_r) < NUM_GROUPS;
  assign sts.in_use   = emit_f < num_fields_r;
  assign sts.is_last  = (j_r == 4'hF) || (emit_f_next >= num_fields_r);
  assign sts.out_free = !out_valid_r || !out_stall;

  a_step_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit_step |-> (!out_valid_r || !out_stall))
    else $error("result register overwritten while held");

endmodule

// ----- rtl/ptbrf_ctrl.sv -----
`timescale 1ns / 1ps
// Controller: sequences capture, row update and per-field result emission.
module ptbrf_ctrl import ptbrf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output ctrl_cmd_t cmd,
  input  dp_sts_t   sts
);

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (sts.grp_ok && (sts.cmd == CMD_READ)) state_nxt = ST_EMIT;
        else state_nxt = ST_IDLE;
      end
      ST_EMIT: begin
        if (!sts.in_use) state_nxt = ST_IDLE;
        else if (sts.out_free && sts.is_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      ST_EXEC: begin
        cmd.row_wr     = sts.grp_ok && ((sts.cmd == CMD_CLEAR) || (sts.cmd == CMD_ACCUM));
        cmd.emit_start = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit_step = sts.in_use && sts.out_free;
      end
      default: ;
    endcase
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_EXEC))
    else $error("accepted word not executed");

  a_exec_once: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EXEC) |=> (state_r != ST_EXEC))
    else $error("execute state repeated");

  a_wr_ok: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.row_wr |-> (sts.grp_ok && (sts.cmd != CMD_READ)))
    else $error("row written for bad group or read");

endmodule

// ----- rtl/packed_two_bit_range_filter_count_core.sv -----
`timescale 1ns / 1ps
// Top level of the packed two-bit range filter count core.
// A word is accepted in the idle state, which reads its group row into registers; clear
// and accumulate write the row back in the execute state while the input is stalled.
// A read emits one result per cycle in the emit state while the output is not stalled;
// the input stays stalled until the last result, which may wait in the output register
// without blocking the next word. Reset clears control and sets the config registers;
// rows have no reset value: the user must clear each group before use (not enforced).
module packed_two_bit_range_filter_count_core import ptbrf_pkg::*; #(
  parameter int MAX_FIELDS = DEF_MAX_FIELDS,
  parameter int COUNT_BITS = DEF_COUNT_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_word
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  ptbrf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  ptbrf_dp #(
    .MAX_FIELDS (MAX_FIELDS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_word   (in_word),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_word  (out_word),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the packed two-bit range filter count core.
module tb_top;
  import ptbrf_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int NUM_GROUPS     = DEF_MAX_FIELDS / FIELDS_PER_WORD;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int BURST_WORDS    = 24;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_valid;
  logic                  in_stall;
  in_word_t              in_word;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_word_t             out_word;

  // predictor state
  logic [15:0] group_mask [NUM_GROUPS];
  logic [15:0] field_count [DEF_MAX_FIELDS];
  logic [NUM_GROUPS-1:0] cleared_grp = '0;
  int cfg_fields = 1024;
  int cfg_low    = 0;
  int cfg_high   = 4;

  out_word_t expected_fields [$];

  int words_sent      = 0;
  int ignored_words   = 0;
  int results_seen    = 0;
  int mismatch_count  = 0;
  int idle_cycles     = 0;
  int burst_left      = 0;
  bit no_gaps         = 1'b0;
  int stall_mode      = 0;
  logic [31:0] stall_tick = '0;

  packed_two_bit_range_filter_count_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void predict_word(input in_word_t w);
    int base;
    int f;
    int code;
    int j;
    out_word_t r;
    base = int'(w.group_index) * FIELDS_PER_WORD;
    case (w.command)
      CMD_CLEAR: begin
        group_mask[w.group_index] = 16'hFFFF;
        for (j = 0; j < FIELDS_PER_WORD; j++) field_count[base + j] = 16'd0;
        cleared_grp[w.group_index] = 1'b1;
      end
      CMD_ACCUM: begin
        for (j = 0; j < FIELDS_PER_WORD; j++) begin
          f = base + j;
          code = int'(w.packed_word[31 - 2 * j -: 2]);
          if (f < cfg_fields) begin
            if (code < cfg_low || code >= cfg_high) group_mask[w.group_index][j] = 1'b0;
            if (code > cfg_low && code < cfg_high && field_count[f] != 16'hFFFF)
              field_count[f] = field_count[f] + 16'd1;
          end
        end
      end
      CMD_READ: begin
        for (j = 0; j < FIELDS_PER_WORD; j++) begin
          f = base + j;
          if (f < cfg_fields) begin
            r.field_number = f[9:0];
            r.all_in_range = group_mask[w.group_index][j];
            r.match_count  = field_count[f];
            r.last         = (j == FIELDS_PER_WORD - 1) || (f + 1 >= cfg_fields);
            expected_fields.push_back(r);
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  task automatic send_word(input logic [1:0] cmd, input int grp, input logic [31:0] data);
    in_word_t w;
    int gap;
    w.command     = cmd;
    w.group_index = grp[5:0];
    w.packed_word = data;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (!no_gaps && gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (cmd == CMD_UNUSED) ignored_words++;
    else words_sent++;
    predict_word(w);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_fields.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input logic [10:0] nf, input logic [2:0] lo, input logic [2:0] hi);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_NUM_FIELDS;
    cfg_wdata <= nf;
    @(posedge clk);
    cfg_index <= CFG_RANGE_LOW;
    cfg_wdata <= {8'd0, lo};
    @(posedge clk);
    cfg_index <= CFG_RANGE_HIGH;
    cfg_wdata <= {8'd0, hi};
    @(posedge clk);
    cfg_we     <= 1'b0;
    cfg_fields = int'(nf);
    cfg_low    = int'(lo);
    cfg_high   = int'(hi);
    burst_left = 0;
  endtask

  // reset values of the registers, every code, ignored command, top group
  task automatic test_reset_config();
    send_word(CMD_CLEAR, 0, 32'h0000_0000);
    send_word(CMD_ACCUM, 0, 32'h0000_0000);
    send_word(CMD_ACCUM, 0, 32'hFFFF_FFFF);
    send_word(CMD_ACCUM, 0, 32'h1B1B_1B1B);
    send_word(CMD_READ, 0, 32'h0000_0000);
    send_word(CMD_UNUSED, 0, 32'hFFFF_FFFF);
    send_word(CMD_READ, 0, 32'hFFFF_FFFF);
    send_word(CMD_CLEAR, NUM_GROUPS - 1, 32'hFFFF_FFFF);
    send_word(CMD_ACCUM, NUM_GROUPS - 1, 32'hE4E4_E4E4);
    send_word(CMD_READ, NUM_GROUPS - 1, 32'h0000_0000);
  endtask

  // narrow, inverted and out-of-code-space bounds
  task automatic test_range_bounds();
    set_config(11'd1024, 3'd1, 3'd3);
    send_word(CMD_CLEAR, 42, 32'h0);
    send_word(CMD_ACCUM, 42, 32'h1B1B_1B1B);
    send_word(CMD_READ, 42, 32'h0);
    set_config(11'd1024, 3'd3, 3'd1);
    send_word(CMD_CLEAR, 21, 32'h0);
    send_word(CMD_ACCUM, 21, 32'hE4E4_E4E4);
    send_word(CMD_READ, 21, 32'h0);
    set_config(11'd1024, 3'd7, 3'd5);
    send_word(CMD_ACCUM, 42, 32'hFFFF_FFFF);
    send_word(CMD_READ, 42, 32'h0);
  endtask

  // reads stop at the field limit, including zero and the widest value
  task automatic test_field_limit();
    set_config(11'd20, 3'd0, 3'd4);
    send_word(CMD_CLEAR, 1, 32'h0);
    send_word(CMD_CLEAR, 2, 32'h0);
    send_word(CMD_ACCUM, 1, $urandom);
    send_word(CMD_ACCUM, 2, $urandom);
    send_word(CMD_READ, 1, 32'h0);
    send_word(CMD_READ, 2, 32'h0);
    set_config(11'd0, 3'd0, 3'd4);
    send_word(CMD_READ, 0, 32'h0);
    set_config(11'd2047, 3'd0, 3'd7);
    send_word(CMD_READ, NUM_GROUPS - 1, 32'h0);
  endtask

  // drive back-to-back accumulates into one group with no sender gaps
  task automatic test_full_rate();
    set_config(11'd1024, 3'd0, 3'd4);
    no_gaps = 1'b1;
    send_word(CMD_CLEAR, 37, 32'h0);
    repeat (BURST_WORDS) send_word(CMD_ACCUM, 37, 32'h5AF0_5AF0);
    send_word(CMD_READ, 37, 32'h0);
    no_gaps = 1'b0;
  endtask

  task automatic run_traffic(input int n);
    int stop_at;
    int pick;
    int k;
    int g;
    stop_at = words_sent + n;
    while (words_sent < stop_at) begin
      pick = $urandom_range(0, 9);
      g = $urandom_range(0, NUM_GROUPS - 1);
      if (pick < 7) begin
        send_word(CMD_CLEAR, g, $urandom);
        k = $urandom_range(1, 6);
        repeat (k) send_word(CMD_ACCUM, g, $urandom);
        send_word(CMD_READ, g, $urandom);
      end else if (pick == 7) begin
        send_word(CMD_UNUSED, g, $urandom);
      end else begin
        while (!cleared_grp[g]) g = $urandom_range(0, NUM_GROUPS - 1);
        send_word((pick == 8) ? CMD_READ : CMD_ACCUM, g, $urandom);
      end
    end
  endtask

  task automatic test_random_traffic();
    int phase;
    logic [10:0] nf;
    logic [2:0] lo;
    logic [2:0] hi;
    for (phase = 0; phase < 5; phase++) begin
      if (phase == 0) begin
        nf = 11'd1024;
        lo = 3'd0;
        hi = 3'd4;
      end else begin
        nf = ($urandom_range(0, 3) == 0) ? 11'($urandom_range(0, 2047))
                                         : 11'($urandom_range(1, 1024));
        lo = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
                                         : 3'($urandom_range(0, 2));
        hi = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7))
                                         : 3'($urandom_range(2, 4));
      end
      set_config(nf, lo, hi);
      run_traffic(18);
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= CFG_NUM_FIELDS;
    cfg_wdata <= '0;
    in_valid  <= 1'b0;
    in_word   <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_config();
    test_range_bounds();
    test_field_limit();
    test_full_rate();
    test_random_traffic();
    wait_idle();
    $display("covered %0d words (%0d ignored) and %0d results over reset, bounds,",
             words_sent, ignored_words, results_seen);
    $display("field-limit, full-rate and random phases with sender gaps and receiver stalls");
    if (mismatch_count == 0 && expected_fields.size() == 0) begin
      $display("packed_two_bit_range_filter_count_core: match");
    end else begin
      $display("packed_two_bit_range_filter_count_core: mismatch");
    end
    $finish;
  end

  // receiver stall pattern
  always @(posedge clk) begin
    stall_tick <= stall_tick + 1;
    if (stall_tick[6:0] == 7'd0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_tick[4:2] == 3'b111);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (expected_fields.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, got field %0d air %0b count %0d last %0b",
                 $realtime, out_word.field_number, out_word.all_in_range,
                 out_word.match_count, out_word.last);
      end else begin
        if (out_word.field_number !== expected_fields[0].field_number ||
            out_word.all_in_range !== expected_fields[0].all_in_range ||
            out_word.match_count !== expected_fields[0].match_count ||
            out_word.last !== expected_fields[0].last) begin
          mismatch_count++;
          $display("%0t: expected %0d/%0b/%0d/%0b got %0d/%0b/%0d/%0b",
                   $realtime, expected_fields[0].field_number,
                   expected_fields[0].all_in_range, expected_fields[0].match_count,
                   expected_fields[0].last, out_word.field_number, out_word.all_in_range,
                   out_word.match_count, out_word.last);
        end
        void'(expected_fields.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles, %0d results outstanding",
                 $realtime, idle_cycles, expected_fields.size());
        $display("packed_two_bit_range_filter_count_core: mismatch");
        $finish;
      end
    end
  end

endmodule
